FILE: hdl/stb_pkg.sv
// Shared package for the software timer bank: function and mode codes,
// field widths and the request wave passed along the row of timer cells.
// No dependencies.
`default_nettype none

package stb_pkg;

	localparam int KEY_WIDTH   = 8;
	localparam int COUNT_WIDTH = 16;
	localparam int STEP_WIDTH  = 8;
	localparam int MASK_WIDTH  = 16;
	localparam int SLOT_WIDTH  = 4;
	localparam int IDX_W       = 6;   // holds a cell index for up to 64 slots
	localparam int SLOTS_DEF   = 16;

	// request codes
	localparam logic [1:0] FUNC_ARM  = 2'd0;
	localparam logic [1:0] FUNC_STOP = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	// timer modes; idle marks a slot that ticks skip
	localparam logic [1:0] MODE_CSET = 2'd0;
	localparam logic [1:0] MODE_ONCE = 2'd1;
	localparam logic [1:0] MODE_TOG  = 2'd2;
	localparam logic [1:0] MODE_IDLE = 2'd3;

	// one request walking the cell row, one cell per cycle
	typedef struct packed {
		logic                   valid;
		logic [1:0]             func;
		logic [KEY_WIDTH-1:0]   key;
		logic [COUNT_WIDTH-1:0] period;
		logic [1:0]             mode;
		logic [STEP_WIDTH-1:0]  step;
		logic                   hit;
		logic [IDX_W-1:0]       idx;
	} wave_t;

endpackage

`default_nettype wire

FILE: hdl/stb_cell.sv
// One timer slot of the bank: key, reload, count, mode and flag.
// Acts on the request wave as it passes and hands it to the next cell.
// Depends on stb_pkg.
`default_nettype none

module stb_cell #(
	parameter int IDX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  stb_pkg::wave_t     wave_in,
	output stb_pkg::wave_t     wave_out,
	output logic               flag,
	output logic               fired
);
	import stb_pkg::*;

	localparam logic [IDX_W-1:0] IDX_V = IDX_W'(IDX);

	logic                   used_q;
	logic                   kvalid_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [COUNT_WIDTH-1:0] reload_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [1:0]             mode_q;
	logic                   flag_q;
	logic                   fired_q;
	wave_t                  wave_q;

	logic                   match;
	logic                   arm_take;
	logic                   stop_take;
	logic                   tick_live;
	logic                   tick_fire;
	logic [COUNT_WIDTH-1:0] step_ext;
	wave_t                  wave_next;

	// decide what this cell does with the passing request
	always_comb begin
		match     = kvalid_q && (key_q == wave_in.key);
		step_ext  = COUNT_WIDTH'(wave_in.step);
		arm_take  = wave_in.valid && (wave_in.func == FUNC_ARM) && !wave_in.hit &&
			(match || !used_q);
		stop_take = wave_in.valid && (wave_in.func == FUNC_STOP) && !wave_in.hit && match;
		tick_live = wave_in.valid && (wave_in.func == FUNC_TICK) && used_q &&
			(mode_q != MODE_IDLE);
		tick_fire = tick_live && (count_q < step_ext);
		// mark the wave once this cell takes the request
		wave_next = wave_in;
		if (arm_take || stop_take) begin
			wave_next.hit = 1'b1;
			wave_next.idx = IDX_V;
		end
	end

	// control state, count, flag and the forwarded wave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= 1'b0;
			kvalid_q <= 1'b0;
			count_q  <= '0;
			flag_q   <= 1'b0;
			fired_q  <= 1'b0;
			wave_q   <= '0;
		end else begin
			wave_q <= wave_next;
			if (wave_in.valid) begin
				fired_q <= tick_fire;
			end
			if (arm_take) begin
				used_q   <= 1'b1;
				kvalid_q <= 1'b1;
				if (wave_in.mode == MODE_ONCE) begin
					count_q <= wave_in.period;
				end
			end
			if (stop_take) begin
				kvalid_q <= 1'b0;
			end
			// advance the countdown, or expire and reload (a one-shot clears instead)
			if (tick_live) begin
				if (!tick_fire) begin
					count_q <= count_q - step_ext;
				end else begin
					case (mode_q)
						MODE_CSET: begin
							count_q <= reload_q;
							flag_q  <= 1'b1;
						end
						MODE_ONCE: begin
							count_q <= '0;
							flag_q  <= 1'b1;
						end
						default: begin
							count_q <= reload_q;
							flag_q  <= ~flag_q;
						end
					endcase
				end
			end
		end
	end

	// slot payload, written on arm and stop, idled on one-shot expiry
	always_ff @(posedge clk) begin
		if (arm_take) begin
			key_q    <= wave_in.key;
			reload_q <= wave_in.period;
			mode_q   <= wave_in.mode;
		end else if (stop_take || (tick_fire && (mode_q == MODE_ONCE))) begin
			mode_q <= MODE_IDLE;
		end
	end

	assign wave_out = wave_q;
	assign flag     = flag_q;
	assign fired    = fired_q;

endmodule

`default_nettype wire

FILE: hdl/multi_slot_software_timer_bank.sv
// Top level of the keyed software timer bank: request launch, the row of
// timer cells and the result register. Depends on stb_pkg and stb_cell.
//
//   channel   handshake        payload
//   request   start / busy     func, key, period, mode, tick_step
//   result    done (strobe)    status, slot, fired_mask, flag_mask
//
// The done strobe rises once the request has left the last cell and the result
// register has taken it; the next request can be taken in the done cycle, so the
// bank takes no new request before the last one is through the cell row, which
// the request walks one slot per cycle.
// busy is high from the accepting edge until the cycle done is shown; start
// may be raised again in the done cycle.
// Reset clears all slots at once; no clearing pass is needed.
// Each result stands for one cycle; the receiver cannot stall it.
`default_nettype none

module multi_slot_software_timer_bank #(
	parameter int SLOTS = stb_pkg::SLOTS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       func,
	input  wire logic [stb_pkg::KEY_WIDTH-1:0]    key,
	input  wire logic [stb_pkg::COUNT_WIDTH-1:0]  period,
	input  wire logic [1:0]                       mode,
	input  wire logic [stb_pkg::STEP_WIDTH-1:0]   tick_step,
	output logic                                  done,
	output logic                                  status,
	output logic [stb_pkg::SLOT_WIDTH-1:0]        slot,
	output logic [stb_pkg::MASK_WIDTH-1:0]        fired_mask,
	output logic [stb_pkg::MASK_WIDTH-1:0]        flag_mask
);
	import stb_pkg::*;

	wave_t                 launch_q;
	wave_t                 chain [SLOTS+1];
	wave_t                 last;
	logic [SLOTS:0]        wave_valid;
	logic [SLOTS-1:0]      flags;
	logic [SLOTS-1:0]      fires;
	logic [MASK_WIDTH-1:0] flag16;
	logic [MASK_WIDTH-1:0] fired16;
	logic                  accept;
	logic                  busy_q;
	logic                  done_q;
	logic                  status_q;
	logic [SLOT_WIDTH-1:0] slot_q;
	logic [MASK_WIDTH-1:0] fired_mask_q;
	logic [MASK_WIDTH-1:0] flag_mask_q;

	assign accept = start && !busy_q;

	// launch the request wave on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
		end else begin
			launch_q.valid  <= accept;
			launch_q.func   <= func;
			launch_q.key    <= key;
			launch_q.period <= period;
			launch_q.mode   <= mode;
			launch_q.step   <= tick_step;
			launch_q.hit    <= 1'b0;
			launch_q.idx    <= '0;
		end
	end

	assign chain[0] = launch_q;

	// row of timer cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		stb_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wave_in (chain[i]),
			.wave_out(chain[i+1]),
			.flag    (flags[i]),
			.fired   (fires[i])
		);
	end

	for (genvar i = 0; i <= SLOTS; i++) begin : g_valid
		assign wave_valid[i] = chain[i].valid;
	end

	// fit the per-slot bits into the mask fields
	for (genvar b = 0; b < MASK_WIDTH; b++) begin : g_mask
		if (b < SLOTS) begin : g_have
			assign flag16[b]  = flags[b];
			assign fired16[b] = fires[b];
		end else begin : g_none
			assign flag16[b]  = 1'b0;
			assign fired16[b] = 1'b0;
		end
	end

	assign last = chain[SLOTS];

	// hold busy and register the result when the wave leaves the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last.valid) begin
			status_q     <= ((last.func == FUNC_ARM) || (last.func == FUNC_STOP)) && !last.hit;
			slot_q       <= last.hit ? last.idx[SLOT_WIDTH-1:0] : '0;
			fired_mask_q <= (last.func == FUNC_TICK) ? fired16 : '0;
			flag_mask_q  <= flag16;
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign fired_mask = fired_mask_q;
	assign flag_mask  = flag_mask_q;

	// at most one request in flight anywhere in the row
	a_one_wave: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wave_valid))
		else $error("more than one request wave in the cell row");

	// a transfer makes the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not raised after a transfer");

	// the result frees the block
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("busy still high with the result strobe");

	// a result only follows a wave leaving the last cell
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(last.valid))
		else $error("result strobe without a finished request");

endmodule

`default_nettype wire
